/* sv/mjt_pkg.sv */
// Shared types, constants and helpers for the minimum-jerk trajectory generator.
// No dependencies; every other file imports this package.
package mjt_pkg;

    localparam int VAL_W     = 32;
    localparam int STEP_W    = 16;
    localparam int RATE_W    = 16;
    localparam int PH_FRAC   = 28;
    localparam int PH_W      = PH_FRAC + 1;
    localparam int DIV_W     = 56;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int DEN_W     = STEP_W;
    localparam int MUL_A_W   = 40;
    localparam int MUL_B_W   = 36;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_CLIP_EXP = 40;
    localparam int ADDR_W    = 4;

    localparam logic [32:0] INNER_BASE = 33'(10) << PH_FRAC;
    localparam logic [29:0] PH_ONE2    = 30'(1) << PH_FRAC;
    localparam logic [PH_W-1:0] PH_ONE = PH_W'(1) << PH_FRAC;

    typedef enum logic [3:0] {
        OP_NONE, OP_STEP, OP_DIV_S, OP_S2, OP_S3, OP_U, OP_P, OP_G,
        OP_H, OP_PM, OP_VX, OP_DIV_V, OP_AX, OP_DIV_A1, OP_DIV_A2, OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic div_done;
        logic clip;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic [VAL_W-1:0]  start_pos;
        logic [VAL_W-1:0]  target_pos;
        logic [RATE_W-1:0] rate;
        logic [STEP_W-1:0] steps;
    } cfg_t;

    typedef enum logic [ADDR_W-3:0] {
        REG_START  = 2'd0,
        REG_TARGET = 2'd1,
        REG_RATE   = 2'd2,
        REG_STEPS  = 2'd3
    } reg_idx_t;

    // Saturate a magnitude with sign to the signed output range; MSB is the clip flag.
    function automatic logic [VAL_W:0] sat_mag(input logic [DIV_W-1:0] mag, input logic neg);
        logic over;
        logic [VAL_W-1:0] val;
        begin
            if (neg) begin
                over = (|mag[DIV_W-1:VAL_W]) || (mag[VAL_W-1] && (|mag[VAL_W-2:0]));
                val  = over ? {1'b1, {(VAL_W-1){1'b0}}} : (~mag[VAL_W-1:0] + 1'b1);
            end else begin
                over = |mag[DIV_W-1:VAL_W-1];
                val  = over ? {1'b0, {(VAL_W-1){1'b1}}} : mag[VAL_W-1:0];
            end
            sat_mag = {over, val};
        end
    endfunction

endpackage

/* sv/min_jerk_trajectory_generator.sv */
// Top level of the minimum-jerk trajectory generator: APB registers, controller, datapath.
// Depends on mjt_pkg, mjt_ctrl, mjt_datapath.
//
// Each input beat (s_valid/s_ready, field s_restart) is one sample tick: restart
// begins a move at step 1, otherwise the move advances one step up to step_count.
// Each tick yields one result beat on m_valid/m_ready with position, velocity and
// acceleration in signed Q16.16, the step index, a last-step flag and a clip flag.
// A tick inside a move runs through a check, four divisions by the step count on one
// bit-serial divider (start, 56 quotient bits, done), nine single-multiplier steps
// and an emit step. A clipped acceleration skips the last division. Ticks before a
// move or after its end go from the check straight to the emit step.
// One tick is in flight at a time; s_ready is high only while idle.
// A finished result waits in the output register, and the next tick is accepted
// and computed meanwhile; a stalled receiver holds the block before its next beat.
// Reset clears the step counter and move state (no move, step 0) and loads the
// registers with start 0, target 0, sample rate 1000 and step count 1000.
// Registers sit at byte offsets 0x0 start, 0x4 target, 0x8 rate, 0xC step count.
module min_jerk_trajectory_generator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mjt_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_restart,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mjt_pkg::VAL_W-1:0]   m_position,
    output logic [mjt_pkg::VAL_W-1:0]   m_velocity,
    output logic [mjt_pkg::VAL_W-1:0]   m_acceleration,
    output logic [mjt_pkg::STEP_W-1:0]  m_step_index,
    output logic                        m_last_step,
    output logic                        m_saturated
);
    import mjt_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    cmd_t     cmd;
    stat_t    stat;
    reg_idx_t widx;
    logic     wr_en;

    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (widx)
                REG_START:  cfg_next.start_pos  = pwdata[VAL_W-1:0];
                REG_TARGET: cfg_next.target_pos = pwdata[VAL_W-1:0];
                REG_RATE:   cfg_next.rate       = pwdata[RATE_W-1:0];
                REG_STEPS:  cfg_next.steps      = pwdata[STEP_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_START:  prdata = cfg_reg.start_pos;
            REG_TARGET: prdata = cfg_reg.target_pos;
            REG_RATE:   prdata = 32'(cfg_reg.rate);
            REG_STEPS:  prdata = 32'(cfg_reg.steps);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_pos  <= '0;
            cfg_reg.target_pos <= '0;
            cfg_reg.rate       <= RATE_W'(1000);
            cfg_reg.steps      <= STEP_W'(1000);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mjt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mjt_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .stat           (stat),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_position     (m_position),
        .m_velocity     (m_velocity),
        .m_acceleration (m_acceleration),
        .m_step_index   (m_step_index),
        .m_last_step    (m_last_step),
        .m_saturated    (m_saturated)
    );

    a_step_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_STEP) |-> (s_valid && s_ready))
        else $error("step issued without an accepted beat");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT) |-> (!m_valid || m_ready))
        else $error("result written over a pending beat");

    a_idle_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_step_index == '0) |->
        (!m_last_step && !m_saturated && m_velocity == '0 && m_acceleration == '0))
        else $error("result before any move is not at rest");

endmodule

/* sv/mjt_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on mjt_pkg.
module mjt_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [mjt_pkg::DIV_W-1:0]  num,
    input  logic [mjt_pkg::DEN_W-1:0]  den,
    output logic                       done,
    output logic [mjt_pkg::DIV_W-1:0]  quo
);
    import mjt_pkg::*;

    logic [DIV_W-1:0]     num_reg, num_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DEN_W:0]       rem_sh;
    logic [DEN_W+1:0]     diff;
    logic                 ge;

    assign rem_sh = {rem_reg, num_reg[DIV_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den};
    assign ge     = !diff[DEN_W+1];

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            num_next = num;
            rem_next = '0;
            cnt_next = DIV_CNT_W'(DIV_W);
            run_next = 1'b1;
        end else if (run_reg) begin
            rem_next = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            num_next = {num_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

/* sv/mjt_datapath.sv */
// Datapath: step state, phase polynomials on a shared multiplier, divider, output beat.
// Depends on mjt_pkg and mjt_div.
module mjt_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mjt_pkg::cfg_t             cfg,
    input  mjt_pkg::cmd_t             cmd,
    output mjt_pkg::stat_t            stat,
    input  logic                      s_restart,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [mjt_pkg::VAL_W-1:0] m_position,
    output logic [mjt_pkg::VAL_W-1:0] m_velocity,
    output logic [mjt_pkg::VAL_W-1:0] m_acceleration,
    output logic [mjt_pkg::STEP_W-1:0] m_step_index,
    output logic                      m_last_step,
    output logic                      m_saturated
);
    import mjt_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              active_reg, active_next;
    logic [PH_W-1:0]   s_reg, s_next, s2_reg, s2_next, s3_reg, s3_next;
    logic [31:0]       inner_reg, inner_next;
    logic [26:0]       u_reg, u_next;
    logic [29:0]       p_reg, p_next, g_reg, g_next;
    logic [32:0]       hm_reg, hm_next;
    logic [33:0]       pm_reg, pm_next;
    logic [35:0]       x_reg, x_next;
    logic [DIV_W-1:0]  vm_reg, vm_next, am_reg, am_next;
    op_t               dst_reg, dst_next;

    logic              mv_reg, mv_next;
    logic [VAL_W-1:0]  pos_reg, pos_next, vel_reg, vel_next, acc_reg, acc_next;
    logic [STEP_W-1:0] idx_reg, idx_next;
    logic              last_reg, last_next, sat_reg, sat_next;

    logic [STEP_W-1:0] n;
    logic [32:0]       d, dm;
    logic              dneg, hneg, clip;
    logic [29:0]       two_s, wm;
    logic [32:0]       inner;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;
    logic [MUL_P_W-PH_FRAC-1:0] sh;
    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_num, div_quo;
    logic [34:0]       pos_sum, pm_ext;
    logic [VAL_W:0]    vel_sat, acc_sat;
    logic              pos_over;

    assign n     = (cfg.steps == '0) ? STEP_W'(1) : cfg.steps;
    assign d     = {cfg.target_pos[VAL_W-1], cfg.target_pos}
                 - {cfg.start_pos[VAL_W-1], cfg.start_pos};
    assign dneg  = d[32];
    assign dm    = dneg ? (~d + 1'b1) : d;
    assign two_s = {s_reg, 1'b0};
    assign hneg  = two_s > PH_ONE2;
    assign wm    = hneg ? (two_s - PH_ONE2) : (PH_ONE2 - two_s);
    assign inner = INNER_BASE + 33'(s2_reg) * 33'd6 - 33'(s_reg) * 33'd15;
    assign clip  = |am_reg[DIV_W-1:ACC_CLIP_EXP];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_S2:     begin mul_a = MUL_A_W'(s_reg);  mul_b = MUL_B_W'(s_reg); end
            OP_S3:     begin mul_a = MUL_A_W'(s2_reg); mul_b = MUL_B_W'(s_reg); end
            OP_U:      begin mul_a = MUL_A_W'(s_reg);  mul_b = MUL_B_W'(PH_ONE - s_reg); end
            OP_P:      begin mul_a = MUL_A_W'(s3_reg); mul_b = MUL_B_W'(inner_reg); end
            OP_G:      begin
                mul_a = MUL_A_W'(32'(u_reg) * 32'd30);
                mul_b = MUL_B_W'(u_reg);
            end
            OP_H:      begin
                mul_a = MUL_A_W'(32'(u_reg) * 32'd60);
                mul_b = MUL_B_W'(wm);
            end
            OP_PM:     begin mul_a = MUL_A_W'(dm);    mul_b = MUL_B_W'(p_reg); end
            OP_VX:     begin mul_a = MUL_A_W'(dm);    mul_b = MUL_B_W'(g_reg); end
            OP_AX:     begin mul_a = MUL_A_W'(dm);    mul_b = MUL_B_W'(hm_reg); end
            OP_DIV_V,
            OP_DIV_A1: begin mul_a = MUL_A_W'(x_reg); mul_b = MUL_B_W'(cfg.rate); end
            OP_DIV_A2: begin
                mul_a = am_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(cfg.rate);
            end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign sh   = prod[MUL_P_W-1:PH_FRAC];

    assign div_start = (cmd.op == OP_DIV_S) || (cmd.op == OP_DIV_V) || (cmd.op == OP_DIV_A1)
                     || ((cmd.op == OP_DIV_A2) && !clip);
    assign div_num   = (cmd.op == OP_DIV_S) ? DIV_W'({step_reg, {PH_FRAC{1'b0}}})
                                            : prod[DIV_W-1:0];

    mjt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (n),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign pm_ext   = 35'(pm_reg);
    assign pos_sum  = {{3{cfg.start_pos[VAL_W-1]}}, cfg.start_pos}
                    + (dneg ? (~pm_ext + 1'b1) : pm_ext);
    assign pos_over = !((&pos_sum[34:VAL_W-1]) || !(|pos_sum[34:VAL_W-1]));
    assign vel_sat  = sat_mag(vm_reg, dneg);
    assign acc_sat  = sat_mag(am_reg, dneg ^ hneg);

    always_comb begin
        step_next   = step_reg;
        active_next = active_reg;
        s_next      = s_reg;
        s2_next     = s2_reg;
        s3_next     = s3_reg;
        inner_next  = inner_reg;
        u_next      = u_reg;
        p_next      = p_reg;
        g_next      = g_reg;
        hm_next     = hm_reg;
        pm_next     = pm_reg;
        x_next      = x_reg;
        vm_next     = vm_reg;
        am_next     = am_reg;
        dst_next    = dst_reg;
        mv_next     = mv_reg && !m_ready;
        pos_next    = pos_reg;
        vel_next    = vel_reg;
        acc_next    = acc_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        sat_next    = sat_reg;

        if (div_start) begin
            dst_next = cmd.op;
        end
        if (div_done) begin
            unique case (dst_reg)
                OP_DIV_S:  s_next  = div_quo[PH_W-1:0];
                OP_DIV_V:  vm_next = div_quo;
                OP_DIV_A1,
                OP_DIV_A2: am_next = div_quo;
                default:   s_next  = s_reg;
            endcase
        end

        unique case (cmd.op)
            OP_STEP: begin
                if (s_restart) begin
                    step_next   = STEP_W'(1);
                    active_next = 1'b1;
                end else if (active_reg) begin
                    if (step_reg < n) begin
                        step_next = step_reg + 1'b1;
                    end else begin
                        active_next = 1'b0;
                    end
                end
            end
            OP_S2:  s2_next = sh[PH_W-1:0];
            OP_S3:  s3_next = sh[PH_W-1:0];
            OP_U: begin
                u_next     = sh[26:0];
                inner_next = inner[31:0];
            end
            OP_P:   p_next  = sh[29:0];
            OP_G:   g_next  = sh[29:0];
            OP_H:   hm_next = sh[32:0];
            OP_PM:  pm_next = sh[33:0];
            OP_VX,
            OP_AX:  x_next  = sh[35:0];
            OP_DIV_A2: begin
                if (clip) begin
                    am_next = DIV_W'(1) << ACC_CLIP_EXP;
                end
            end
            OP_EMIT: begin
                mv_next  = 1'b1;
                idx_next = step_reg;
                if (active_reg) begin
                    pos_next  = pos_over ? (pos_sum[34] ? {1'b1, {(VAL_W-1){1'b0}}}
                                                        : {1'b0, {(VAL_W-1){1'b1}}})
                                         : pos_sum[VAL_W-1:0];
                    vel_next  = vel_sat[VAL_W-1:0];
                    acc_next  = acc_sat[VAL_W-1:0];
                    last_next = (step_reg == n);
                    sat_next  = pos_over || vel_sat[VAL_W] || acc_sat[VAL_W];
                end else begin
                    pos_next  = (step_reg == '0) ? cfg.start_pos : cfg.target_pos;
                    vel_next  = '0;
                    acc_next  = '0;
                    last_next = (step_reg != '0);
                    sat_next  = 1'b0;
                end
            end
            default: begin
                s2_next = s2_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= '0;
            active_reg <= 1'b0;
            mv_reg     <= 1'b0;
            dst_reg    <= OP_NONE;
        end else begin
            step_reg   <= step_next;
            active_reg <= active_next;
            mv_reg     <= mv_next;
            dst_reg    <= dst_next;
        end
        s_reg     <= s_next;
        s2_reg    <= s2_next;
        s3_reg    <= s3_next;
        inner_reg <= inner_next;
        u_reg     <= u_next;
        p_reg     <= p_next;
        g_reg     <= g_next;
        hm_reg    <= hm_next;
        pm_reg    <= pm_next;
        x_reg     <= x_next;
        vm_reg    <= vm_next;
        am_reg    <= am_next;
        pos_reg   <= pos_next;
        vel_reg   <= vel_next;
        acc_reg   <= acc_next;
        idx_reg   <= idx_next;
        last_reg  <= last_next;
        sat_reg   <= sat_next;
    end

    assign stat.active   = active_reg;
    assign stat.div_done = div_done;
    assign stat.clip     = clip;
    assign stat.out_free = !mv_reg || m_ready;

    assign m_valid        = mv_reg;
    assign m_position     = pos_reg;
    assign m_velocity     = vel_reg;
    assign m_acceleration = acc_reg;
    assign m_step_index   = idx_reg;
    assign m_last_step    = last_reg;
    assign m_saturated    = sat_reg;

endmodule

/* sv/mjt_ctrl.sv */
// Controller state machine: sequences the datapath operations for one tick.
// Depends on mjt_pkg.
module mjt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mjt_pkg::stat_t stat,
    output mjt_pkg::cmd_t  cmd
);
    import mjt_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE    = 20'h00001,
        S_CHECK   = 20'h00002,
        S_DIV_S   = 20'h00004,
        S_WAIT_S  = 20'h00008,
        S_S2      = 20'h00010,
        S_S3      = 20'h00020,
        S_U       = 20'h00040,
        S_P       = 20'h00080,
        S_G       = 20'h00100,
        S_H       = 20'h00200,
        S_PM      = 20'h00400,
        S_VX      = 20'h00800,
        S_DIV_V   = 20'h01000,
        S_WAIT_V  = 20'h02000,
        S_AX      = 20'h04000,
        S_DIV_A1  = 20'h08000,
        S_WAIT_A1 = 20'h10000,
        S_DIV_A2  = 20'h20000,
        S_WAIT_A2 = 20'h40000,
        S_EMIT    = 20'h80000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_STEP;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:   state_next = stat.active ? S_DIV_S : S_EMIT;
            S_DIV_S:   begin cmd.op = OP_DIV_S; state_next = S_WAIT_S; end
            S_WAIT_S:  if (stat.div_done) begin state_next = S_S2; end
            S_S2:      begin cmd.op = OP_S2; state_next = S_S3; end
            S_S3:      begin cmd.op = OP_S3; state_next = S_U; end
            S_U:       begin cmd.op = OP_U;  state_next = S_P; end
            S_P:       begin cmd.op = OP_P;  state_next = S_G; end
            S_G:       begin cmd.op = OP_G;  state_next = S_H; end
            S_H:       begin cmd.op = OP_H;  state_next = S_PM; end
            S_PM:      begin cmd.op = OP_PM; state_next = S_VX; end
            S_VX:      begin cmd.op = OP_VX; state_next = S_DIV_V; end
            S_DIV_V:   begin cmd.op = OP_DIV_V; state_next = S_WAIT_V; end
            S_WAIT_V:  if (stat.div_done) begin state_next = S_AX; end
            S_AX:      begin cmd.op = OP_AX; state_next = S_DIV_A1; end
            S_DIV_A1:  begin cmd.op = OP_DIV_A1; state_next = S_WAIT_A1; end
            S_WAIT_A1: if (stat.div_done) begin state_next = S_DIV_A2; end
            S_DIV_A2: begin
                cmd.op     = OP_DIV_A2;
                state_next = stat.clip ? S_EMIT : S_WAIT_A2;
            end
            S_WAIT_A2: if (stat.div_done) begin state_next = S_EMIT; end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

/* verif/testbench.sv */
// Testbench for min_jerk_trajectory_generator: drives ticks and APB register writes,
// predicts every result beat and checks it field by field. Depends on mjt_pkg and the RTL.
module testbench;
    import mjt_pkg::*;

    typedef struct {
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
        logic [15:0] idx;
        logic        last;
        logic        sat;
    } sample_t;

    class trajectory_scoreboard;
        logic [31:0] start_pos = 0;
        logic [31:0] target_pos = 0;
        logic [15:0] rate = 16'd1000;
        logic [15:0] steps = 16'd1000;
        longint unsigned step_k = 0;
        bit moving = 0;
        sample_t expected_q[$];
        int errors = 0;

        function void set_reg(reg_idx_t idx, logic [31:0] val);
            case (idx)
                REG_START: start_pos = val;
                REG_TARGET: target_pos = val;
                REG_RATE: rate = val[15:0];
                REG_STEPS: steps = val[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] clip(longint x, inout bit flag);
            if (x > 64'sd2147483647) begin
                flag = 1;
                return 32'h7fffffff;
            end
            if (x < -64'sd2147483648) begin
                flag = 1;
                return 32'h80000000;
            end
            return x[31:0];
        endfunction

        function longint signed_mag(longint unsigned mag, bit neg);
            return neg ? -longint'(mag) : longint'(mag);
        endfunction

        function void note_tick(bit restart);
            longint unsigned n, f, s, s2, s3, inner, p, u, g, wm, hm, pm, vm, am, dm;
            longint unsigned one;
            longint q0, qf, d;
            bit dneg, hneg, sat;
            sample_t r;
            one = 64'd1 << 28;
            n = steps;
            if (n == 0) n = 1;
            f = rate;
            q0 = $signed(start_pos);
            qf = $signed(target_pos);
            sat = 0;
            if (restart) begin
                step_k = 1;
                moving = 1;
            end else if (moving) begin
                if (step_k < n) step_k++;
                else moving = 0;
            end
            if (moving) begin
                d = qf - q0;
                dneg = d < 0;
                dm = dneg ? longint'(-d) : longint'(d);
                s = (step_k << 28) / n;
                s2 = (s * s) >> 28;
                s3 = (s2 * s) >> 28;
                inner = 10 * one + 6 * s2 - 15 * s;
                p = (s3 * inner) >> 28;
                u = (s * (one - s)) >> 28;
                g = (30 * u * u) >> 28;
                hneg = (2 * s) > one;
                wm = hneg ? (2 * s - one) : (one - 2 * s);
                hm = (60 * u * wm) >> 28;
                pm = (dm * p) >> 28;
                vm = (((dm * g) >> 28) * f) / n;
                am = (((dm * hm) >> 28) * f) / n;
                if (f != 0) begin
                    if (am >= (64'd1 << 40)) am = 64'd1 << 40;
                    else am = (am * f) / n;
                end
                r.pos = clip(q0 + signed_mag(pm, dneg), sat);
                r.vel = clip(signed_mag(vm, dneg), sat);
                r.acc = clip(signed_mag(am, dneg != hneg), sat);
                r.last = (step_k == n);
            end else if (step_k == 0) begin
                r.pos = start_pos;
                r.vel = 0;
                r.acc = 0;
                r.last = 0;
            end else begin
                r.pos = target_pos;
                r.vel = 0;
                r.acc = 0;
                r.last = 1;
            end
            r.idx = step_k[15:0];
            r.sat = sat;
            expected_q = {expected_q, r};
        endfunction

        function void check_sample(sample_t got);
            sample_t exp_s;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result beat pos=%h", $time, got.pos);
                errors++;
                return;
            end
            exp_s = expected_q.pop_front();
            if (got.pos !== exp_s.pos) begin
                $display("%0t: position exp %h got %h", $time, exp_s.pos, got.pos);
                errors++;
            end
            if (got.vel !== exp_s.vel) begin
                $display("%0t: velocity exp %h got %h", $time, exp_s.vel, got.vel);
                errors++;
            end
            if (got.acc !== exp_s.acc) begin
                $display("%0t: acceleration exp %h got %h", $time, exp_s.acc, got.acc);
                errors++;
            end
            if (got.idx !== exp_s.idx) begin
                $display("%0t: step_index exp %0d got %0d", $time, exp_s.idx, got.idx);
                errors++;
            end
            if (got.last !== exp_s.last) begin
                $display("%0t: last_step exp %b got %b", $time, exp_s.last, got.last);
                errors++;
            end
            if (got.sat !== exp_s.sat) begin
                $display("%0t: saturated exp %b got %b", $time, exp_s.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [ADDR_W-1:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 0;
    logic s_ready;
    logic s_restart = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [VAL_W-1:0] m_position, m_velocity, m_acceleration;
    logic [STEP_W-1:0] m_step_index;
    logic m_last_step, m_saturated;

    trajectory_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    longint unsigned cycles = 0;
    int move_len = 0;
    int move_pos = 0;

    min_jerk_trajectory_generator u_dut (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge aclk)
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge aclk) begin
        sample_t got;
        if (aresetn && m_valid && m_ready) begin
            got.pos = m_position;
            got.vel = m_velocity;
            got.acc = m_acceleration;
            got.idx = m_step_index;
            got.last = m_last_step;
            got.sat = m_saturated;
            sb.check_sample(got);
        end
    end

    task automatic send_tick(bit restart);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 0;
        end
        @(negedge aclk);
        s_valid <= 1;
        s_restart <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_tick(restart);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        sb.set_reg(idx, val);
        @(negedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic write_all(logic [31:0] q0, logic [31:0] qf, logic [15:0] f, logic [15:0] n);
        write_reg(REG_START, q0);
        write_reg(REG_TARGET, qf);
        write_reg(REG_RATE, {16'd0, f});
        write_reg(REG_STEPS, {16'd0, n});
    endtask

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hffff;
            3: return 16'($urandom_range(1, 2000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_steps();
        case ($urandom_range(0, 19))
            0: return 16'd0;
            1: return 16'hffff;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 3))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        send_tick(0);
        send_tick(0);
        drain();
        write_all(32'h80000000, 32'h7fffffff, 16'hffff, 16'd3);
        send_tick(1);
        repeat (4) send_tick(0);
        drain();
        write_all(32'h7fffffff, 32'h80000000, 16'd1, 16'd0);
        send_tick(1);
        send_tick(0);
        send_tick(0);
        drain();
        write_all(32'h00010000, 32'hfffe0000, 16'd0, 16'd5);
        send_tick(1);
        repeat (3) send_tick(0);
        drain();
        write_reg(REG_STEPS, 32'd2);
        send_tick(0);
        send_tick(0);
        send_tick(1);
        send_tick(0);
        send_tick(1);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            int lim;
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            write_all(pick_pos(), pick_pos(), pick_rate(), pick_steps());
            lim = (sb.steps == 0) ? 1 : sb.steps;
            move_pos = 0;
            move_len = 0;
            for (int i = 0; i < 135; i++) begin
                bit rs;
                if (move_pos >= move_len) begin
                    rs = ($urandom_range(0, 9) != 0);
                    move_len = (lim > 40 ? 30 : lim) + $urandom_range(0, 3);
                    move_pos = 0;
                end else begin
                    rs = ($urandom_range(0, 24) == 0);
                end
                move_pos++;
                send_tick(rs);
            end
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

/* min_jerk_trajectory_generator.f */
sv/mjt_pkg.sv
sv/mjt_div.sv
sv/mjt_datapath.sv
sv/mjt_ctrl.sv
sv/min_jerk_trajectory_generator.sv
verif/testbench.sv
